### hw/rtl/edist_pkg.sv
// ----------------------------------------------------------------------------
// edist_pkg
// Shared widths and controller/datapath interface types for the euclidean
// distance block.
// ----------------------------------------------------------------------------
package edist_pkg;

    // element field width on the ports, and the bits of it that are used
    localparam int ELEM_WIDTH = 16;
    localparam int DATA_WIDTH = 16;

    // difference of two elements, and its square
    localparam int DIFF_WIDTH = DATA_WIDTH + 1;
    localparam int SQ_WIDTH   = 2 * DIFF_WIDTH;

    // Q28.16 accumulator and the Q14.8 root taken from it
    localparam int SUM_WIDTH  = 44;
    localparam int ROOT_WIDTH = SUM_WIDTH / 2;
    localparam int ROOT_STEPS = SUM_WIDTH / 2;
    localparam int CNT_WIDTH  = $clog2(ROOT_STEPS);

    // controller -> datapath
    typedef struct packed {
        logic take;       // input item accepted this cycle
        logic root_load;  // load root unit from the final sum
        logic root_step;  // run one root round
        logic out_load;   // move the finished root into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sq_last;    // last square of the vector is at the accumulator
        logic out_full;   // output register holds an item not yet taken
    } status_t;

endpackage

### hw/rtl/edist_ctrl.sv
// ----------------------------------------------------------------------------
// edist_ctrl
// Sequencer: accepts element pairs, waits for the last one to reach the
// accumulator, steps the root unit and hands the result to the output register.
// ----------------------------------------------------------------------------
module edist_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_element,
    output logic                 in_ready,
    input  logic                 out_ready,
    input  edist_pkg::status_t   status,
    output edist_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_ACC    = 2'd0;
    localparam logic [1:0] ST_DRAIN  = 2'd1;
    localparam logic [1:0] ST_ROOT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [edist_pkg::CNT_WIDTH-1:0] CNT_LAST =
        edist_pkg::CNT_WIDTH'(edist_pkg::ROOT_STEPS - 1);

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [edist_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic [edist_pkg::CNT_WIDTH-1:0] cnt_next;

    assign in_ready = (state_reg == ST_ACC);

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.take      = 1'b0;
        cmd.root_load = 1'b0;
        cmd.root_step = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                cmd.take = in_valid;
                if (in_valid && last_element)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.sq_last)
                begin
                    cmd.root_load = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hw/rtl/edist_dp.sv
// ----------------------------------------------------------------------------
// edist_dp
// Datapath: difference stage, square stage, saturating Q28.16 accumulator,
// bit-per-round square root unit and output register.
// ----------------------------------------------------------------------------
module edist_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [edist_pkg::ELEM_WIDTH-1:0]       element_a,
    input  logic [edist_pkg::ELEM_WIDTH-1:0]       element_b,
    input  logic                                   last_element,
    input  edist_pkg::cmd_t                        cmd,
    output edist_pkg::status_t                     status,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [edist_pkg::ROOT_WIDTH-1:0]       distance,
    output logic                                   saturated
);

    localparam int DW = edist_pkg::DATA_WIDTH;
    localparam int SW = edist_pkg::SUM_WIDTH;

    // difference stage
    logic                                   diff_valid_reg;
    logic                                   diff_last_reg;
    logic signed [edist_pkg::DIFF_WIDTH-1:0] diff_reg;
    logic signed [edist_pkg::DIFF_WIDTH-1:0] a_ext;
    logic signed [edist_pkg::DIFF_WIDTH-1:0] b_ext;

    // square stage
    logic                                   sq_valid_reg;
    logic                                   sq_last_reg;
    logic [edist_pkg::SQ_WIDTH-1:0]          sq_reg;
    logic signed [edist_pkg::SQ_WIDTH-1:0]   sq_next;

    // accumulator
    logic [SW-1:0]                          sum_reg;
    logic                                   ovf_reg;
    logic [SW:0]                            sum_ext;
    logic [SW-1:0]                          sum_acc;
    logic                                   ovf_acc;

    // root unit
    logic [SW-1:0]                          rem_reg;
    logic [SW-1:0]                          root_reg;
    logic [SW-1:0]                          bit_reg;
    logic                                   root_sat_reg;
    logic [SW-1:0]                          trial;

    // output register
    logic                                   out_valid_reg;
    logic [edist_pkg::ROOT_WIDTH-1:0]       distance_reg;
    logic                                   saturated_reg;

    // sign-extend the used element bits and subtract
    assign a_ext = {element_a[DW-1], element_a[DW-1:0]};
    assign b_ext = {element_b[DW-1], element_b[DW-1:0]};

    // square of a signed difference is never negative
    assign sq_next = diff_reg * diff_reg;

    // saturating add of the square
    assign sum_ext = {1'b0, sum_reg} + (SW + 1)'(sq_reg);
    assign sum_acc = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
    assign ovf_acc = ovf_reg | sum_ext[SW];

    // root round: trial subtract of root + bit
    assign trial = root_reg + bit_reg;

    assign status.sq_last  = sq_valid_reg & sq_last_reg;
    assign status.out_full = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign saturated = saturated_reg;

    // pipeline control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            diff_last_reg  <= 1'b0;
            sq_valid_reg   <= 1'b0;
            sq_last_reg    <= 1'b0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            diff_valid_reg <= cmd.take;
            diff_last_reg  <= cmd.take & last_element;
            sq_valid_reg   <= diff_valid_reg;
            sq_last_reg    <= diff_last_reg;
            if (sq_valid_reg)
            begin
                if (sq_last_reg)
                begin
                    sum_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_acc;
                    ovf_reg <= ovf_acc;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            diff_reg <= b_ext - a_ext;
        end
        if (diff_valid_reg)
        begin
            sq_reg <= unsigned'(sq_next);
        end
        if (cmd.root_load)
        begin
            rem_reg      <= sum_acc;
            root_reg     <= '0;
            bit_reg      <= SW'(1) << (SW - 2);
            root_sat_reg <= ovf_acc;
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.out_load)
        begin
            distance_reg  <= root_reg[edist_pkg::ROOT_WIDTH-1:0];
            saturated_reg <= root_sat_reg;
        end
    end

endmodule

### hw/rtl/euclidean_distance.sv
// ----------------------------------------------------------------------------
// euclidean_distance
// Euclidean distance of two signed Q8.8 vectors, one element pair per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries element_a, element_b and
//   last_element. Within a vector one item is taken every cycle.
//   Each pair adds (b - a)^2 to a saturating Q28.16 sum. On the item with
//   last_element set, the block takes the floor square root of the sum and
//   sends one item on the output channel (out_valid/out_ready): distance in
//   unsigned Q14.8 and saturated, set if the sum hit its ceiling.
//   After the last item is accepted it passes the difference/square
//   pipeline, the last square is added and the root unit loaded, the
//   one-bit-per-cycle root unit runs 22 rounds, and the result moves
//   into the output register, where out_valid rises.
//   in_ready stays low from the last item until the result is loaded.
//   The output register holds the result until taken; a stalled receiver
//   only blocks the next vector at the point its result would be loaded.
//   Reset clears the sum, the overflow flag and all valid state.
// ----------------------------------------------------------------------------
module euclidean_distance (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [edist_pkg::ELEM_WIDTH-1:0]   element_a,
    input  logic [edist_pkg::ELEM_WIDTH-1:0]   element_b,
    input  logic                               last_element,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [edist_pkg::ROOT_WIDTH-1:0]   distance,
    output logic                               saturated
);

    edist_pkg::cmd_t    cmd;
    edist_pkg::status_t status;

    // sequencer
    edist_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .last_element (last_element),
        .in_ready     (in_ready),
        .out_ready    (out_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic
    edist_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .element_a    (element_a),
        .element_b    (element_b),
        .last_element (last_element),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .distance     (distance),
        .saturated    (saturated)
    );

endmodule

### hw/rtl/edist_checker.sv
// ----------------------------------------------------------------------------
// edist_checker
// Port-level checks for euclidean_distance, bound to the top level.
// ----------------------------------------------------------------------------
module edist_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [edist_pkg::ELEM_WIDTH-1:0]   element_a,
    input logic [edist_pkg::ELEM_WIDTH-1:0]   element_b,
    input logic                               last_element,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [edist_pkg::ROOT_WIDTH-1:0]   distance,
    input logic                               saturated
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(saturated))
        else $error("output item changed while stalled");

    // no new item is taken right after the end of a vector
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_element |=> !in_ready)
        else $error("input taken during root computation");

    // a result appears only after the input side was closed
    a_rise_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a finished vector");

    // a saturated sum gives the largest root
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> distance == {edist_pkg::ROOT_WIDTH{1'b1}})
        else $error("saturated result with wrong distance");

    // no input item accepted without its fields defined
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !$isunknown({element_a, element_b, last_element}))
        else $error("unknown input item accepted");

endmodule

bind euclidean_distance edist_checker u_edist_checker (.*);
